### rtl/serial_frame_deframer_assert.svh
// Assertion macros used by the deframer checker.
`ifndef SERIAL_FRAME_DEFRAMER_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define SFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication, idle during reset.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

### rtl/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

   localparam int CNT_W      = 32;
   localparam int OUT_CNT_W  = 32;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 16;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 2 * BYTE_W - BYTE_W + 2 * LEN_W + 4 * OUT_CNT_W;
   localparam int RSP_USER_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] FL_MOD = 8'hFF;
   localparam logic [15:0] MAX_LEN_RESET = 16'd255;

   typedef enum logic [2:0] {
      PH_MAGIC_HI = 3'd0,
      PH_MAGIC_LO = 3'd1,
      PH_LEN_HI   = 3'd2,
      PH_LEN_LO   = 3'd3,
      PH_PAYLOAD  = 3'd4,
      PH_CK_HI    = 3'd5,
      PH_CK_LO    = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      CMD_BYTE         = 2'd0,
      CMD_PARSER_RESET = 2'd1,
      CMD_CLEAR_STATS  = 2'd2
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_MAGIC   = 1'b0,
      CSR_MAX_LEN = 1'b1
   } csr_reg_type;

   // (a + b) mod 255 for a < 255, b <= 255; the sum stays below 510.
   function automatic logic [BYTE_W-1:0] mod255_add(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
      logic [BYTE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, FL_MOD}) begin
         s = s - {1'b0, FL_MOD};
      end
      return s[BYTE_W-1:0];
   endfunction

endpackage

### rtl/serial_frame_deframer.sv
`timescale 1ns / 1ps

// Byte-serial frame deframer with a Fletcher-16 check.
// req channel: one transfer per item; req_tuser is the command (0 byte,
// 1 reset parser, 2 clear statistics), req_tdata the received byte.
// rsp channel: exactly one transfer per req transfer, in order. rsp_tuser
// flags payload byte, frame end and good frame; rsp_tdata carries the byte,
// its index, the good frame length and the four statistics counters as
// they stand after the item.
// The result is registered and shown in the cycle after its req transfer. The
// parser state and the Fletcher sums update on the same edge, so one item is
// taken every cycle while rsp_tready stays high.
// When the receiver stalls, the result register holds and req_tready drops
// until the result is taken; a new item enters in the same cycle the old
// result leaves.
// Reset clears the parser and the counters, empties the result register,
// sets the magic word to 0 and the length limit to 255; req_tready is low
// in reset.
// The csr port (APB) holds the magic word at 0x0 and the length limit at
// 0x4; write it only while no item is in flight.
module serial_frame_deframer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] rx_byte
   input  logic [sfd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] command
   input  logic [sfd_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] data_byte, [23:8] data_index, [39:24] frame_length,
   // [71:40] frames_ok_count, [103:72] checksum_error_count,
   // [135:104] length_error_count, [167:136] resync_count
   output logic [sfd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] data_valid, [1] frame_end, [2] frame_good
   output logic [sfd_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sfd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int BW = sfd_pkg::BYTE_W;
   localparam int LW = sfd_pkg::LEN_W;
   localparam int CW = sfd_pkg::CNT_W;
   localparam int OW = sfd_pkg::OUT_CNT_W;

   // configuration
   logic [LW-1:0] magic_ff, magic_in;
   logic [LW-1:0] max_len_ff, max_len_in;
   logic          csr_wr;
   sfd_pkg::csr_reg_type csr_sel;

   // parser state
   sfd_pkg::phase_type phase_ff, phase_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] taken_ff, taken_in;
   logic [BW-1:0] ck_hi_ff, ck_hi_in;
   logic [BW-1:0] sum_lo_ff, sum_lo_in;
   logic [BW-1:0] sum_hi_ff, sum_hi_in;
   logic [CW-1:0] good_ff, good_in;
   logic [CW-1:0] bad_ck_ff, bad_ck_in;
   logic [CW-1:0] bad_len_ff, bad_len_in;
   logic [CW-1:0] skip_ff, skip_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sfd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [sfd_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic             req_fire;
   logic             rsp_fire;
   sfd_pkg::cmd_type cmd;
   logic [BW-1:0]    rx;
   logic [BW-1:0]    marker_hi;
   logic [BW-1:0]    marker_lo;
   logic [LW-1:0]    len_full;
   logic             len_bad;
   logic [LW-1:0]    taken_inc;
   logic [BW-1:0]    sum_lo_next;
   logic             ck_match;

   logic          res_dv;
   logic [BW-1:0] res_byte;
   logic [LW-1:0] res_index;
   logic          res_end;
   logic          res_good;
   logic [LW-1:0] res_len;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;

   assign cmd       = sfd_pkg::cmd_type'(req_tuser);
   assign rx        = req_tdata;
   assign marker_hi = magic_ff[LW-1:BW];
   assign marker_lo = magic_ff[BW-1:0];

   assign len_full    = {len_ff[LW-1:BW], rx};
   assign len_bad     = (len_full == '0) || (len_full > max_len_ff);
   assign taken_inc   = taken_ff + LW'(1);
   assign sum_lo_next = sfd_pkg::mod255_add(sum_lo_ff, rx);
   assign ck_match    = ({sum_hi_ff, sum_lo_ff} == {ck_hi_ff, rx});

   // CSR access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = sfd_pkg::csr_reg_type'(csr_paddr[2]);

   always_comb begin
      magic_in   = magic_ff;
      max_len_in = max_len_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            sfd_pkg::CSR_MAGIC:   magic_in   = csr_pwdata[LW-1:0];
            sfd_pkg::CSR_MAX_LEN: max_len_in = csr_pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         sfd_pkg::CSR_MAGIC:   csr_prdata = sfd_pkg::CSR_DATA_W'(magic_ff);
         sfd_pkg::CSR_MAX_LEN: csr_prdata = sfd_pkg::CSR_DATA_W'(max_len_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         unique case (cmd)
            sfd_pkg::CMD_PARSER_RESET: phase_in = sfd_pkg::PH_MAGIC_HI;
            sfd_pkg::CMD_BYTE: begin
               unique case (phase_ff)
                  sfd_pkg::PH_MAGIC_LO: begin
                     if (rx == marker_lo) begin
                        phase_in = sfd_pkg::PH_LEN_HI;
                     end else if (rx != marker_hi) begin
                        phase_in = sfd_pkg::PH_MAGIC_HI;
                     end
                  end
                  sfd_pkg::PH_LEN_HI: phase_in = sfd_pkg::PH_LEN_LO;
                  sfd_pkg::PH_LEN_LO: begin
                     phase_in = len_bad ? sfd_pkg::PH_MAGIC_HI : sfd_pkg::PH_PAYLOAD;
                  end
                  sfd_pkg::PH_PAYLOAD: begin
                     if (taken_inc == len_ff) begin
                        phase_in = sfd_pkg::PH_CK_HI;
                     end
                  end
                  sfd_pkg::PH_CK_HI: phase_in = sfd_pkg::PH_CK_LO;
                  sfd_pkg::PH_CK_LO: phase_in = sfd_pkg::PH_MAGIC_HI;
                  // hunt for the magic high byte, also for the unused code
                  default: begin
                     phase_in = (rx == marker_hi) ? sfd_pkg::PH_MAGIC_LO
                                                  : sfd_pkg::PH_MAGIC_HI;
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   // datapath, counters and result fields
   always_comb begin
      len_in     = len_ff;
      taken_in   = taken_ff;
      ck_hi_in   = ck_hi_ff;
      sum_lo_in  = sum_lo_ff;
      sum_hi_in  = sum_hi_ff;
      good_in    = good_ff;
      bad_ck_in  = bad_ck_ff;
      bad_len_in = bad_len_ff;
      skip_in    = skip_ff;
      res_dv     = 1'b0;
      res_byte   = '0;
      res_index  = '0;
      res_end    = 1'b0;
      res_good   = 1'b0;
      res_len    = '0;
      if (req_fire) begin
         unique case (cmd)
            sfd_pkg::CMD_PARSER_RESET: begin
               len_in    = '0;
               taken_in  = '0;
               ck_hi_in  = '0;
               sum_lo_in = '0;
               sum_hi_in = '0;
            end
            sfd_pkg::CMD_CLEAR_STATS: begin
               good_in    = '0;
               bad_ck_in  = '0;
               bad_len_in = '0;
               skip_in    = '0;
            end
            sfd_pkg::CMD_BYTE: begin
               unique case (phase_ff)
                  sfd_pkg::PH_MAGIC_LO: begin
                     // a repeated high byte still counts as a start
                     if (rx == marker_lo) begin
                        skip_in = skip_ff;
                     end else if (rx == marker_hi) begin
                        skip_in = skip_ff + CW'(1);
                     end else begin
                        skip_in = skip_ff + CW'(2);
                     end
                  end
                  sfd_pkg::PH_LEN_HI: len_in = {rx, BW'(0)};
                  sfd_pkg::PH_LEN_LO: begin
                     len_in = len_full;
                     if (len_bad) begin
                        bad_len_in = bad_len_ff + CW'(1);
                     end else begin
                        taken_in  = '0;
                        sum_lo_in = '0;
                        sum_hi_in = '0;
                     end
                  end
                  sfd_pkg::PH_PAYLOAD: begin
                     res_dv    = 1'b1;
                     res_byte  = rx;
                     res_index = taken_ff;
                     sum_lo_in = sum_lo_next;
                     sum_hi_in = sfd_pkg::mod255_add(sum_hi_ff, sum_lo_next);
                     taken_in  = taken_inc;
                  end
                  sfd_pkg::PH_CK_HI: ck_hi_in = rx;
                  sfd_pkg::PH_CK_LO: begin
                     res_end = 1'b1;
                     if (ck_match) begin
                        good_in  = good_ff + CW'(1);
                        res_good = 1'b1;
                        res_len  = len_ff;
                     end else begin
                        bad_ck_in = bad_ck_ff + CW'(1);
                     end
                  end
                  default: begin
                     if (rx != marker_hi) begin
                        skip_in = skip_ff + CW'(1);
                     end
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   // result register: load on a req transfer, drop after the rsp transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {OW'(skip_in), OW'(bad_len_in), OW'(bad_ck_in), OW'(good_in),
                         res_len, res_index, res_byte};
         rsp_user_in  = {res_good, res_end, res_dv};
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff     <= '0;
         max_len_ff   <= sfd_pkg::MAX_LEN_RESET;
         phase_ff     <= sfd_pkg::PH_MAGIC_HI;
         len_ff       <= '0;
         taken_ff     <= '0;
         ck_hi_ff     <= '0;
         sum_lo_ff    <= '0;
         sum_hi_ff    <= '0;
         good_ff      <= '0;
         bad_ck_ff    <= '0;
         bad_len_ff   <= '0;
         skip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         magic_ff     <= magic_in;
         max_len_ff   <= max_len_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         taken_ff     <= taken_in;
         ck_hi_ff     <= ck_hi_in;
         sum_lo_ff    <= sum_lo_in;
         sum_hi_ff    <= sum_hi_in;
         good_ff      <= good_in;
         bad_ck_ff    <= bad_ck_in;
         bad_len_ff   <= bad_len_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### rtl/sfd_checker.sv
`timescale 1ns / 1ps
`include "serial_frame_deframer_assert.svh"

module sfd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [sfd_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic req_fire;
   logic rsp_stall;
   logic rsp_empty;
   logic payload_shown;
   logic payload_clean;
   logic [sfd_pkg::RSP_DATA_W+sfd_pkg::RSP_USER_W-1:0] rsp_word;

   assign req_fire      = req_tvalid && req_tready;
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign rsp_empty     = !reset && !rsp_tvalid;
   assign payload_shown = rsp_tvalid && rsp_tuser[0];
   assign payload_clean = !rsp_tuser[1] && !rsp_tuser[2] && (rsp_tdata[39:24] == 16'd0);
   assign rsp_word      = {rsp_tdata, rsp_tuser};

   // a stalled result holds
   `SFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // every req transfer shows its result in the next cycle
   `SFD_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_fire, rsp_tvalid)

   // an empty result register never blocks the input
   `SFD_ASSERT_NOW(a_ready_when_empty, clock, reset, rsp_empty, req_tready)

   // a payload byte never ends a frame and carries no frame length
   `SFD_ASSERT_NOW(a_payload_flags, clock, reset, payload_shown, payload_clean)

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
